[rtl/core/hcbp_pkg.sv]
package hcbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int BYTE_BITS    = 8;

    localparam int CMD_W     = 2;
    localparam int SYM_W     = 8;
    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int SYM_IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ENTRY_W   = CODE_W + LEN_W;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAPTURE,
        ST_PACK,
        ST_FLUSH,
        ST_FAULT
    } state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic capture;
        logic step;
        logic flush;
        logic fault;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic pending_any;
        logic out_free;
        logic step_emits;
        logic step_final;
    } dp_status_t;

endpackage

[rtl/core/hcbp_ram.sv]
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/hcbp_datapath.sv]
module hcbp_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [hcbp_pkg::SYM_W-1:0]     symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]    code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]     code_length,
    input  hcbp_pkg::ctrl_cmd_t            cmd,
    output hcbp_pkg::dp_status_t           status,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hcbp_pkg::BYTE_BITS-1:0] out_byte,
    output logic                           last,
    output logic                           error
);

    function automatic logic [hcbp_pkg::BYTE_BITS-1:0] low_mask(input logic [3:0] n);
        low_mask = hcbp_pkg::BYTE_BITS'((9'd1 << n) - 9'd1);
    endfunction

    logic [hcbp_pkg::SYMBOL_COUNT-1:0] loaded_reg, loaded_next;
    logic [2:0]                        count_reg, count_next;
    logic [hcbp_pkg::BYTE_BITS-1:0]    pending_reg, pending_next;
    logic [hcbp_pkg::CODE_W-1:0]       code_reg, code_next;
    logic [hcbp_pkg::LEN_W-1:0]        rem_reg, rem_next;
    logic                              out_valid_reg, out_valid_next;
    logic [hcbp_pkg::BYTE_BITS-1:0]    out_byte_reg, out_byte_next;
    logic                              last_reg, last_next;
    logic                              error_reg, error_next;

    logic [hcbp_pkg::SYM_IDX_W-1:0]    sym_idx;
    logic                              in_range;
    logic [hcbp_pkg::LEN_W-1:0]        len_clamped;
    logic [hcbp_pkg::ENTRY_W-1:0]      ram_rdata;
    logic [3:0]                        need;
    logic                              emits;
    logic [hcbp_pkg::LEN_W-1:0]        rem_after;
    logic                              final_step;
    logic [hcbp_pkg::CODE_W-1:0]       shifted;
    logic [hcbp_pkg::BYTE_BITS-1:0]    pending_up;
    logic [hcbp_pkg::BYTE_BITS-1:0]    step_byte;
    logic [hcbp_pkg::BYTE_BITS-1:0]    absorb_byte;
    logic                              out_free;
    logic                              out_write;

    assign sym_idx  = hcbp_pkg::SYM_IDX_W'(symbol);
    assign in_range = {1'b0, symbol} < 9'(hcbp_pkg::SYMBOL_COUNT);
    assign len_clamped = (code_length > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN))
                       ? hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN) : code_length;

    hcbp_ram #(
        .WIDTH (hcbp_pkg::ENTRY_W),
        .DEPTH (hcbp_pkg::SYMBOL_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (cmd.load && in_range),
        .waddr (sym_idx),
        .wdata ({code_bits, len_clamped}),
        .re    (cmd.read),
        .raddr (sym_idx),
        .rdata (ram_rdata)
    );

    assign need       = 4'(hcbp_pkg::BYTE_BITS) - {1'b0, count_reg};
    assign emits      = rem_reg >= {2'b00, need};
    assign rem_after  = emits ? (rem_reg - {2'b00, need}) : '0;
    assign final_step = !emits || (rem_after < hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_BITS));
    assign shifted    = code_reg >> (rem_reg - {2'b00, need});
    assign pending_up = pending_reg << need;
    assign step_byte  = pending_up | (shifted[hcbp_pkg::BYTE_BITS-1:0] & low_mask(need));
    assign absorb_byte = (pending_reg << rem_reg[2:0])
                       | (code_reg[hcbp_pkg::BYTE_BITS-1:0] & low_mask({1'b0, rem_reg[2:0]}));

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_write = cmd.fault || cmd.flush || (cmd.step && emits);

    assign status.hit         = in_range && loaded_reg[sym_idx];
    assign status.pending_any = count_reg != 3'd0;
    assign status.out_free    = out_free;
    assign status.step_emits  = emits;
    assign status.step_final  = final_step;

    always_comb
    begin
        loaded_next    = loaded_reg;
        count_next     = count_reg;
        pending_next   = pending_reg;
        code_next      = code_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        error_next     = error_reg;

        if (cmd.load && in_range)
        begin
            loaded_next[sym_idx] = 1'b1;
        end

        if (cmd.capture)
        begin
            code_next = ram_rdata[hcbp_pkg::ENTRY_W-1:hcbp_pkg::LEN_W];
            rem_next  = ram_rdata[hcbp_pkg::LEN_W-1:0];
        end

        if (cmd.step)
        begin
            rem_next = rem_after;
            if (emits)
            begin
                out_byte_next = step_byte;
                last_next     = final_step;
                error_next    = 1'b0;
                if (final_step)
                begin
                    pending_next = code_reg[hcbp_pkg::BYTE_BITS-1:0]
                                 & low_mask(rem_after[3:0]);
                    count_next   = rem_after[2:0];
                end
                else
                begin
                    pending_next = '0;
                    count_next   = '0;
                end
            end
            else
            begin
                pending_next = absorb_byte;
                count_next   = count_reg + rem_reg[2:0];
            end
        end

        if (cmd.flush)
        begin
            out_byte_next = pending_up;
            last_next     = 1'b1;
            error_next    = 1'b0;
            pending_next  = '0;
            count_next    = '0;
        end

        if (cmd.fault)
        begin
            out_byte_next = '0;
            last_next     = 1'b1;
            error_next    = 1'b1;
        end

        if (out_write)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            count_reg     <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            loaded_reg    <= loaded_next;
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        rem_reg      <= rem_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        error_reg    <= error_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule

[rtl/core/hcbp_controller.sv]
module hcbp_controller (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [hcbp_pkg::CMD_W-1:0]  command,
    input  hcbp_pkg::dp_status_t        status,
    output hcbp_pkg::ctrl_cmd_t         cmd
);

    hcbp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcbp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        unique case (state_reg)
            hcbp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (command)
                        hcbp_pkg::CMD_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        hcbp_pkg::CMD_ENCODE:
                        begin
                            if (status.hit)
                            begin
                                cmd.read   = 1'b1;
                                state_next = hcbp_pkg::ST_CAPTURE;
                            end
                            else
                            begin
                                state_next = hcbp_pkg::ST_FAULT;
                            end
                        end
                        hcbp_pkg::CMD_FLUSH:
                        begin
                            if (status.pending_any)
                            begin
                                state_next = hcbp_pkg::ST_FLUSH;
                            end
                        end
                        default:
                        begin
                            state_next = hcbp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            hcbp_pkg::ST_CAPTURE:
            begin
                cmd.capture = 1'b1;
                state_next  = hcbp_pkg::ST_PACK;
            end
            hcbp_pkg::ST_PACK:
            begin
                if (!status.step_emits || status.out_free)
                begin
                    cmd.step = 1'b1;
                    if (status.step_final)
                    begin
                        state_next = hcbp_pkg::ST_IDLE;
                    end
                end
            end
            hcbp_pkg::ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = hcbp_pkg::ST_IDLE;
                end
            end
            hcbp_pkg::ST_FAULT:
            begin
                if (status.out_free)
                begin
                    cmd.fault  = 1'b1;
                    state_next = hcbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcbp_pkg::ST_IDLE;
            end
        endcase
    end

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != hcbp_pkg::ST_IDLE) |-> in_stall)
        else $error("input taken while busy");

    a_write_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fault || cmd.flush || (cmd.step && status.step_emits)) |-> status.out_free)
        else $error("output register overwritten");

    a_absorb_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !status.step_emits) |=> (state_reg == hcbp_pkg::ST_IDLE))
        else $error("pack continued after absorbing tail");

    a_capture_then_pack: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |=> (state_reg == hcbp_pkg::ST_CAPTURE) ##1 (state_reg == hcbp_pkg::ST_PACK))
        else $error("table read not followed by capture");

endmodule

[rtl/core/huffman_code_bit_packer_unit.sv]
// Huffman code bit packer.
// Input channel (in_valid/in_stall) carries one command per transaction:
//   load   writes symbol's code_bits/code_length into the code table, no result;
//   encode looks the symbol up and packs its code MSB first, giving one
//          transaction per completed byte, last set on the final one;
//   flush  pads the waiting bits with zeros at the low end, gives one byte (none if no bits wait).
// Encoding a never-loaded symbol gives one transaction with error set, byte zero.
// Output channel (out_valid/out_stall) gives out_byte, last and error.
// Order of work: load writes the table on acceptance; encode reads the
// table, captures the entry, then makes one packer step per cycle, held
// while a byte-giving step finds the output full; each step gives at most
// one byte. A code that completes no byte still takes one step, a 32-bit
// code at most four. Flush and error results are registered from their
// own FLUSH or FAULT state once the output has room.
// One transaction is worked on at a time; in_stall is low only when idle.
// Reset clears the loaded flags, the packer's waiting bits and the output valid flag; table
// contents are not cleared and need no clearing pass.
// A stalled output holds its byte and the packer waits for room.
module huffman_code_bit_packer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hcbp_pkg::CMD_W-1:0]     command,
    input  logic [hcbp_pkg::SYM_W-1:0]     symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]    code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]     code_length,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hcbp_pkg::BYTE_BITS-1:0] out_byte,
    output logic                           last,
    output logic                           error
);

    hcbp_pkg::ctrl_cmd_t  cmd;
    hcbp_pkg::dp_status_t status;

    hcbp_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .status   (status),
        .cmd      (cmd)
    );

    hcbp_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last        (last),
        .error       (error)
    );

endmodule

[tb/hcbp_byte_checker.sv]
`timescale 1ns / 100ps

module hcbp_byte_checker
    import hcbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [CMD_W-1:0]     command,
    input  logic [SYM_W-1:0]     symbol,
    input  logic [CODE_W-1:0]    code_bits,
    input  logic [LEN_W-1:0]     code_length,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [BYTE_BITS-1:0] out_byte,
    input  logic                 last,
    input  logic                 error,
    output int                   mismatch_count,
    output int                   bytes_waiting
);

    typedef struct packed {
        logic [BYTE_BITS-1:0] data;
        logic                 last;
        logic                 error;
    } packed_byte_t;

    logic [CODE_W-1:0]    code_table   [SYMBOL_COUNT];
    logic [LEN_W-1:0]     length_table [SYMBOL_COUNT];
    logic                 loaded       [SYMBOL_COUNT];
    logic [BYTE_BITS-1:0] acc_bits;
    int                   acc_count;
    int                   fails = 0;
    packed_byte_t         expected_bytes [$];

    task automatic predict_packer(
        input logic [CMD_W-1:0]  cmd,
        input logic [SYM_W-1:0]  sym,
        input logic [CODE_W-1:0] bits,
        input logic [LEN_W-1:0]  len
    );
        logic [BYTE_BITS-1:0] made [4];
        packed_byte_t         entry;
        int                   n;
        int                   i;
        n = 0;
        case (cmd)
            CMD_LOAD:
            begin
                code_table[sym]   = bits;
                length_table[sym] = (len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : len;
                loaded[sym]       = 1'b1;
            end
            CMD_ENCODE:
            begin
                if (!loaded[sym])
                begin
                    entry.data  = '0;
                    entry.last  = 1'b1;
                    entry.error = 1'b1;
                    expected_bytes.push_back(entry);
                end
                else
                begin
                    for (i = int'(length_table[sym]) - 1; i >= 0; i--)
                    begin
                        acc_bits  = {acc_bits[BYTE_BITS-2:0], code_table[sym][i]};
                        acc_count = acc_count + 1;
                        if (acc_count == BYTE_BITS)
                        begin
                            made[n]   = acc_bits;
                            n         = n + 1;
                            acc_bits  = '0;
                            acc_count = 0;
                        end
                    end
                end
            end
            CMD_FLUSH:
            begin
                if (acc_count > 0)
                begin
                    made[0]   = acc_bits << (BYTE_BITS - acc_count);
                    n         = 1;
                    acc_bits  = '0;
                    acc_count = 0;
                end
            end
            default:
            begin
            end
        endcase
        for (i = 0; i < n; i++)
        begin
            entry.data  = made[i];
            entry.last  = (i == n - 1);
            entry.error = 1'b0;
            expected_bytes.push_back(entry);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        packed_byte_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < SYMBOL_COUNT; s++)
            begin
                loaded[s] = 1'b0;
            end
            acc_bits  = '0;
            acc_count = 0;
            expected_bytes.delete();
            mismatch_count <= fails;
            bytes_waiting  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_packer(command, symbol, code_bits, code_length);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    fails = fails + 1;
                    if (fails <= 10)
                    begin
                        $display("%0t unexpected transaction: byte %h last %b error %b",
                                 $realtime, out_byte, last, error);
                    end
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.data || last !== want.last || error !== want.error)
                    begin
                        fails = fails + 1;
                        if (fails <= 10)
                        begin
                            $display("%0t mismatch: expected byte %h last %b error %b, got byte %h last %b error %b",
                                     $realtime, want.data, want.last, want.error,
                                     out_byte, last, error);
                        end
                    end
                end
            end
            mismatch_count <= fails;
            bytes_waiting  <= expected_bytes.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import hcbp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int STALL_NONE   = 0;
    localparam int STALL_LIGHT  = 1;
    localparam int STALL_HEAVY  = 2;
    localparam int STALL_TOGGLE = 3;

    localparam int RANDOM_ITEMS = 160;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     command;
    logic [SYM_W-1:0]     symbol;
    logic [CODE_W-1:0]    code_bits;
    logic [LEN_W-1:0]     code_length;
    logic                 out_valid;
    logic                 out_stall;
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last;
    logic                 error;
    int                   mismatches;
    int                   bytes_waiting;

    int                   burst_left = 0;
    int                   stall_mode = STALL_NONE;
    int                   stall_left = 0;
    logic [SYM_W-1:0]     known_syms [$];

    huffman_code_bit_packer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last        (last),
        .error       (error)
    );

    hcbp_byte_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .symbol         (symbol),
        .code_bits      (code_bits),
        .code_length    (code_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last           (last),
        .error          (error),
        .mismatch_count (mismatches),
        .bytes_waiting  (bytes_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // pick a new stall pattern when the current one runs out
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(STALL_NONE, STALL_TOGGLE);
            stall_left = $urandom_range(10, 80);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
            default:      out_stall <= stall_left[0];
        endcase
    end

    task automatic send_item(
        input logic [CMD_W-1:0]  cmd,
        input logic [SYM_W-1:0]  sym,
        input logic [CODE_W-1:0] bits,
        input logic [LEN_W-1:0]  len
    );
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(1, 6);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        symbol      <= sym;
        code_bits   <= bits;
        code_length <= len;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        burst_left = burst_left - 1;
        if (cmd == CMD_LOAD)
        begin
            known_syms.push_back(sym);
        end
    endtask

    initial
    begin
        int               pick;
        logic [LEN_W-1:0] len;
        logic [SYM_W-1:0] sym;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        command     <= CMD_LOAD;
        symbol      <= '0;
        code_bits   <= '0;
        code_length <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_item(CMD_ENCODE, 8'h00, $urandom, LEN_W'($urandom));
        send_item(CMD_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        send_item(CMD_UNUSED, 8'h00, 32'h0, 6'd0);
        send_item(CMD_LOAD, 8'h00, $urandom, 6'd0);
        send_item(CMD_ENCODE, 8'h00, 32'h0, 6'd0);
        send_item(CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
        send_item(CMD_ENCODE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_item(CMD_LOAD, 8'h01, 32'hFFFF_FFF5, 6'd3);
        send_item(CMD_ENCODE, 8'h01, 32'h0, 6'd0);
        send_item(CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_item(CMD_LOAD, 8'h80, 32'h0000_0000, 6'h3F);
        send_item(CMD_ENCODE, 8'h01, 32'h0, 6'd0);
        send_item(CMD_ENCODE, 8'h80, 32'h0, 6'd0);
        send_item(CMD_LOAD, 8'h55, 32'hAAAA_AAAA, 6'd33);
        send_item(CMD_ENCODE, 8'h55, 32'h0, 6'd0);
        send_item(CMD_LOAD, 8'h02, 32'h0000_0001, 6'd1);
        send_item(CMD_ENCODE, 8'h02, 32'h0, 6'd0);
        send_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
        send_item(CMD_FLUSH, 8'h00, 32'h0, 6'd0);
        send_item(CMD_ENCODE, 8'hAA, 32'h0, 6'd0);
        send_item(CMD_LOAD, 8'h03, 32'h0000_007F, 6'd7);
        send_item(CMD_ENCODE, 8'h03, 32'h0, 6'd0);
        send_item(CMD_ENCODE, 8'h02, 32'h0, 6'd0);
        send_item(CMD_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                case ($urandom_range(0, 9))
                    0:       len = 6'd0;
                    1, 2:    len = LEN_W'($urandom_range(13, 32));
                    3:       len = LEN_W'($urandom_range(33, 63));
                    default: len = LEN_W'($urandom_range(1, 12));
                endcase
                send_item(CMD_LOAD, SYM_W'($urandom), $urandom, len);
            end
            else if (pick < 80)
            begin
                sym = known_syms[$urandom_range(0, known_syms.size() - 1)];
                send_item(CMD_ENCODE, sym, $urandom, LEN_W'($urandom));
            end
            else if (pick < 93)
            begin
                send_item(CMD_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
            end
            else if (pick < 97)
            begin
                send_item(CMD_ENCODE, SYM_W'($urandom), $urandom, LEN_W'($urandom));
            end
            else
            begin
                send_item(CMD_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
            end
        end
        in_valid <= 1'b0;

        do
            @(negedge clk);
        while (bytes_waiting != 0);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && bytes_waiting == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/hcbp_pkg.sv
rtl/core/hcbp_ram.sv
rtl/core/hcbp_datapath.sv
rtl/core/hcbp_controller.sv
rtl/core/huffman_code_bit_packer_unit.sv
tb/hcbp_byte_checker.sv
tb/tb.sv
